// ===== hw/rtl/esd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  // Accumulator width and octal run length
  localparam int VALUE_BITS       = 16;
  localparam int MAX_OCTAL_DIGITS = 3;
  localparam bit OCT_ONE_DIGIT    = (MAX_OCTAL_DIGITS <= 1);

  // Result queue between decoder and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_LOW_A  = 8'd97;
  localparam logic [7:0] CH_LOW_B  = 8'd98;
  localparam logic [7:0] CH_LOW_E  = 8'd101;
  localparam logic [7:0] CH_LOW_F  = 8'd102;
  localparam logic [7:0] CH_LOW_N  = 8'd110;
  localparam logic [7:0] CH_LOW_R  = 8'd114;
  localparam logic [7:0] CH_LOW_T  = 8'd116;
  localparam logic [7:0] CH_LOW_V  = 8'd118;
  localparam logic [7:0] CH_LOW_X  = 8'd120;
  localparam logic [7:0] CH_UP_X   = 8'd88;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_SEVEN  = 8'd55;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_UP_A   = 8'd65;
  localparam logic [7:0] CH_UP_F   = 8'd70;
  localparam logic [7:0] CH_LOW_Z  = 8'd122;
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CASE_GAP  = 8'd32;
  localparam logic [7:0] CARET_OFS = 8'd64;

  // Control codes produced by letter escapes
  localparam logic [15:0] CC_BEL = 16'd7;
  localparam logic [15:0] CC_BS  = 16'd8;
  localparam logic [15:0] CC_ESC = 16'd27;
  localparam logic [15:0] CC_FF  = 16'd12;
  localparam logic [15:0] CC_LF  = 16'd10;
  localparam logic [15:0] CC_CR  = 16'd13;
  localparam logic [15:0] CC_TAB = 16'd9;
  localparam logic [15:0] CC_VT  = 16'd11;
  localparam logic [15:0] CC_CARET_END = 16'd192;

  // One queue entry: the one or two results caused by one input byte
  typedef struct packed {
    logic        two;
    logic [15:0] v0;
    logic [15:0] v1;
  } q_entry_t;

  // Queue status seen by the output stage
  typedef struct packed {
    logic     empty;
    q_entry_t head;
  } q_stat_t;

  // Widen or cut an accumulator value to the 16-bit result
  function automatic logic [15:0] to_char(input logic [VALUE_BITS-1:0] acc);
    logic [31:0] t;
    t = 32'(acc);
    return t[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/esd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esd_front import esd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_mark,
  input  wire logic       push,
  output logic            full,
  input  wire logic       q_full,
  output logic            q_wr,
  output q_entry_t        q_wdata
);

  typedef enum logic [4:0] {
    M_TEXT  = 5'b00001,
    M_ESC   = 5'b00010,
    M_HEX   = 5'b00100,
    M_CARET = 5'b01000,
    M_OCT   = 5'b10000
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]            cnt_r, cnt_nxt;

  logic                  accept;
  logic [7:0]            b;
  logic                  is_oct;
  logic                  is_hex;
  logic [3:0]            hex_d;
  logic [VALUE_BITS-1:0] acc_hex;
  logic [VALUE_BITS-1:0] acc_oct;
  logic [1:0]            cnt_inc;
  logic [7:0]            up_b;
  logic [7:0]            caret_v;
  logic [1:0]            nres;
  logic [15:0]           r0, r1;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign b      = in_text_byte;

  // Classify the byte
  assign is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
  always_comb begin
    is_hex = 1'b1;
    hex_d  = b[3:0];
    if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
      hex_d = b[3:0];
    end else if (((b >= CH_LOW_A) && (b <= CH_LOW_F)) ||
                 ((b >= CH_UP_A) && (b <= CH_UP_F))) begin
      hex_d = b[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign acc_hex = {acc_r[VALUE_BITS-5:0], hex_d};
  assign acc_oct = {acc_r[VALUE_BITS-4:0], b[2:0]};
  assign cnt_inc = cnt_r + 2'd1;
  assign up_b    = ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ? (b - CASE_GAP) : b;
  assign caret_v = up_b - CARET_OFS;

  // Work out the next mode and the results of this byte
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    nres     = 2'd0;
    r0       = 16'd0;
    r1       = 16'd0;
    if (in_end_mark) begin
      mode_nxt = M_TEXT;
      acc_nxt  = '0;
      cnt_nxt  = 2'd0;
      case (mode_r)
        M_ESC: begin
          nres = 2'd1;
          r0   = {8'd0, CH_BSLASH};
        end
        M_HEX, M_OCT: begin
          nres = 2'd1;
          r0   = to_char(acc_r);
        end
        M_CARET: begin
          nres = 2'd1;
          r0   = CC_CARET_END;
        end
        default: ;
      endcase
    end else begin
      case (mode_r)
        M_ESC: begin
          mode_nxt = M_TEXT;
          acc_nxt  = '0;
          cnt_nxt  = 2'd0;
          nres     = 2'd1;
          case (b)
            CH_LOW_A: r0 = CC_BEL;
            CH_LOW_B: r0 = CC_BS;
            CH_LOW_E: r0 = CC_ESC;
            CH_LOW_F: r0 = CC_FF;
            CH_LOW_N: r0 = CC_LF;
            CH_LOW_R: r0 = CC_CR;
            CH_LOW_T: r0 = CC_TAB;
            CH_LOW_V: r0 = CC_VT;
            CH_LOW_X, CH_UP_X: begin
              nres     = 2'd0;
              mode_nxt = M_HEX;
            end
            CH_CARET: begin
              nres     = 2'd0;
              mode_nxt = M_CARET;
            end
            default: begin
              if ((b == 8'd0) || (b > CH_TILDE)) begin
                // emit the backslash, then the byte as plain text
                nres = 2'd2;
                r0   = {8'd0, CH_BSLASH};
                r1   = {8'd0, b};
              end else if (is_oct) begin
                if (OCT_ONE_DIGIT) begin
                  r0 = {13'd0, b[2:0]};
                end else begin
                  nres     = 2'd0;
                  mode_nxt = M_OCT;
                  acc_nxt  = VALUE_BITS'(b[2:0]);
                  cnt_nxt  = 2'd1;
                end
              end else begin
                r0 = {8'd0, b};
              end
            end
          endcase
        end
        M_HEX, M_OCT: begin
          if ((mode_r == M_HEX) && is_hex) begin
            acc_nxt = acc_hex;
          end else if ((mode_r == M_OCT) && is_oct) begin
            if (cnt_inc >= 2'(MAX_OCTAL_DIGITS)) begin
              nres     = 2'd1;
              r0       = to_char(acc_oct);
              mode_nxt = M_TEXT;
              acc_nxt  = '0;
              cnt_nxt  = 2'd0;
            end else begin
              acc_nxt = acc_oct;
              cnt_nxt = cnt_inc;
            end
          end else begin
            // close the run, then take the byte afresh
            r0      = to_char(acc_r);
            acc_nxt = '0;
            cnt_nxt = 2'd0;
            if (b == CH_BSLASH) begin
              nres     = 2'd1;
              mode_nxt = M_ESC;
            end else begin
              nres     = 2'd2;
              r1       = {8'd0, b};
              mode_nxt = M_TEXT;
            end
          end
        end
        M_CARET: begin
          nres     = 2'd1;
          r0       = {8'd0, caret_v};
          mode_nxt = M_TEXT;
          acc_nxt  = '0;
          cnt_nxt  = 2'd0;
        end
        default: begin
          acc_nxt = '0;
          cnt_nxt = 2'd0;
          if (b == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            mode_nxt = M_TEXT;
            nres     = 2'd1;
            r0       = {8'd0, b};
          end
        end
      endcase
    end
  end

  // Push a request only when the byte gives results
  assign q_wr       = accept && (nres != 2'd0);
  assign q_wdata.two = (nres == 2'd2);
  assign q_wdata.v0  = r0;
  assign q_wdata.v1  = r1;

  // Advance decoder state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TEXT;
      acc_r  <= '0;
      cnt_r  <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/esd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esd_queue import esd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  q_entry_t      wdata,
  output logic          q_full,
  input  wire logic     rd,
  output q_stat_t       stat
);

  q_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_wr, do_rd;

  assign q_full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.head  = mem_r[rp_r];
  assign do_wr      = wr && !q_full;
  assign do_rd      = rd && !stat.empty;

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/esd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esd_back import esd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  q_stat_t     stat,
  output logic        rd,
  output logic [15:0] out_char_value,
  output logic        out_last_of_run,
  output logic        empty,
  input  wire logic   pop
);

  logic        vld_r;
  logic        ph_r, ph_nxt;
  logic [15:0] val_r;
  logic        last_r;
  logic        load;
  logic        last_nxt;

  assign empty           = !vld_r;
  assign out_char_value  = val_r;
  assign out_last_of_run = last_r;

  // Load the output register when it is free or being taken
  assign load     = (!vld_r || pop) && !stat.empty;
  assign last_nxt = ph_r || !stat.head.two;
  assign rd       = load && last_nxt;
  assign ph_nxt   = load ? !last_nxt : ph_r;

  always_ff @(posedge clk) begin
    if (load) begin
      val_r  <= ph_r ? stat.head.v1 : stat.head.v0;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ph_r  <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (pop) begin
        vld_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/escape_sequence_decoder_unit.sv =====
// Escape sequence decoder: turns string-literal text into character values.
// Input queue side: present in_text_byte / in_end_mark with push; a byte is
// taken at a clock edge where push is high and full is low. in_end_mark
// closes the string and flushes any open escape.
// Result queue side: while empty is low, out_char_value and out_last_of_run
// show the oldest result; pop high at a clock edge takes it.
// Each byte gives zero, one or two results; out_last_of_run marks the last.
// A result passes through the four-entry result queue and the output register:
// the decoder writes the queue at the edge where its byte is taken, and the
// output register loads from the queue at a later edge once it is free.
// The unit takes one byte per cycle while full is low; the output register
// delivers one result a cycle while the receiver pops, so a byte with two
// results holds it for both, and the queue absorbs the difference.
// When the receiver stalls, results wait in the output register and queue;
// full rises once the queue holds four entries and drops as results leave.
// Reset (rst_n low, synchronous) returns the decoder to plain text mode and
// empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_unit import esd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_mark,
  input  wire logic        push,
  output logic             full,
  output logic [15:0]      out_char_value,
  output logic             out_last_of_run,
  output logic             empty,
  input  wire logic        pop
);

  logic     q_full;
  logic     q_wr;
  q_entry_t q_wdata;
  logic     q_rd;
  q_stat_t  q_stat;

  esd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_text_byte (in_text_byte),
    .in_end_mark  (in_end_mark),
    .push         (push),
    .full         (full),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata)
  );

  esd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .q_full (q_full),
    .rd     (q_rd),
    .stat   (q_stat)
  );

  esd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .stat            (q_stat),
    .rd              (q_rd),
    .out_char_value  (out_char_value),
    .out_last_of_run (out_last_of_run),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

`default_nettype wire

// ===== test/escape_sequence_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module escape_sequence_decoder_unit_test;
  import esd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIR_ROWS       = 25;
  localparam logic [7:0] CH_LOW_G = 8'd103;

  typedef enum logic [2:0] {
    MODE_TEXT, MODE_ESC, MODE_HEX, MODE_CARET, MODE_OCT
  } decode_mode_e;

  typedef enum int {
    TK_PLAIN, TK_LETTER, TK_HEX, TK_OCTAL, TK_CARET, TK_BS_ANY, TK_CUT, TK_NOISE
  } token_kind_e;

  // One text byte request; typed rows carry their results written out
  typedef struct packed {
    logic [7:0]  text;
    logic        endm;
    logic        typed;
    logic [1:0]  n;
    logic [15:0] v0;
    logic [15:0] v1;
  } text_request_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } char_result_t;

  // Directed rows: extremes, the backslash, caret and hex/octal corner cases
  localparam text_request_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{8'hFF,     1'b0, 1'b1, 2'd1, 16'd255, 16'd0},
    '{8'h5A,     1'b1, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{8'hFF,     1'b0, 1'b1, 2'd2, 16'd92,  16'd255},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{8'h00,     1'b0, 1'b1, 2'd2, 16'd92,  16'd0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{8'hA5,     1'b1, 1'b1, 2'd1, 16'd92,  16'd0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_CARET,  1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{8'h00,     1'b1, 1'b1, 2'd1, 16'd192, 16'd0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_CARET,  1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_LOW_A,  1'b0, 1'b0, 2'd0, 16'd0,   16'd0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_SEVEN,  1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_SEVEN,  1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_SEVEN,  1'b0, 1'b0, 2'd0, 16'd0,   16'd0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_LOW_X,  1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_UP_F,   1'b0, 1'b0, 2'd0, 16'd0,   16'd0},
    '{CH_LOW_G,  1'b0, 1'b0, 2'd0, 16'd0,   16'd0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{CH_UP_X,   1'b0, 1'b1, 2'd0, 16'd0,   16'd0},
    '{8'h33,     1'b1, 1'b1, 2'd1, 16'd0,   16'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_text_byte = 8'd0;
  logic        in_end_mark = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic [15:0] out_char_value;
  logic        out_last_of_run;
  logic        empty;

  // Decoder state of the predictor
  decode_mode_e            dec_mode = MODE_TEXT;
  logic [VALUE_BITS-1:0]   dec_acc = '0;
  logic [1:0]              oct_count = '0;
  logic [15:0]             step_chars [2];
  int                      step_count;

  text_request_t text_requests [$];
  text_request_t current_req;
  char_result_t  awaited_chars [$];

  int items_queued = 0;
  int bytes_taken = 0;
  int chars_seen = 0;
  int strings_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  escape_sequence_decoder_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_text_byte    (in_text_byte),
    .in_end_mark     (in_end_mark),
    .push            (push),
    .full            (full),
    .out_char_value  (out_char_value),
    .out_last_of_run (out_last_of_run),
    .empty           (empty),
    .pop             (pop)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void emit_char(input logic [VALUE_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    step_chars[step_count] = wide[15:0];
    step_count++;
  endfunction

  function automatic void clear_escape();
    dec_mode  = MODE_TEXT;
    dec_acc   = '0;
    oct_count = '0;
  endfunction

  // Plain text: a backslash opens an escape, anything else is passed through
  function automatic void take_plain(input logic [7:0] b);
    if (b == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      emit_char(VALUE_BITS'(b));
    end
  endfunction

  // Advance the predictor by one request and leave its characters in step_chars
  function automatic void decode_text_byte(input logic [7:0] b, input logic endm);
    logic [3:0] digit;
    logic       is_hex;
    logic [7:0] upper;
    logic [7:0] caret_val;
    step_count = 0;
    if (endm) begin
      // Flush whatever escape is open
      case (dec_mode)
        MODE_ESC:           emit_char(VALUE_BITS'(CH_BSLASH));
        MODE_HEX, MODE_OCT: emit_char(dec_acc);
        MODE_CARET:         emit_char(VALUE_BITS'(CC_CARET_END));
        default: ;
      endcase
      clear_escape();
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          clear_escape();
          case (b)
            CH_LOW_A: emit_char(VALUE_BITS'(CC_BEL));
            CH_LOW_B: emit_char(VALUE_BITS'(CC_BS));
            CH_LOW_E: emit_char(VALUE_BITS'(CC_ESC));
            CH_LOW_F: emit_char(VALUE_BITS'(CC_FF));
            CH_LOW_N: emit_char(VALUE_BITS'(CC_LF));
            CH_LOW_R: emit_char(VALUE_BITS'(CC_CR));
            CH_LOW_T: emit_char(VALUE_BITS'(CC_TAB));
            CH_LOW_V: emit_char(VALUE_BITS'(CC_VT));
            CH_LOW_X, CH_UP_X: dec_mode = MODE_HEX;
            CH_CARET: dec_mode = MODE_CARET;
            default: begin
              if (b == 8'd0 || b > CH_TILDE) begin
                // Backslash goes out alone, the byte is read again as text
                emit_char(VALUE_BITS'(CH_BSLASH));
                take_plain(b);
              end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
                dec_acc   = VALUE_BITS'(b - CH_ZERO);
                oct_count = 2'd1;
                if (oct_count >= MAX_OCTAL_DIGITS) begin
                  emit_char(dec_acc);
                  clear_escape();
                end else begin
                  dec_mode = MODE_OCT;
                end
              end else begin
                emit_char(VALUE_BITS'(b));
              end
            end
          endcase
        end
        MODE_HEX: begin
          is_hex = 1'b1;
          digit  = 4'd0;
          if (b >= CH_ZERO && b <= CH_NINE) begin
            digit = 4'(b - CH_ZERO);
          end else if (b >= CH_LOW_A && b <= CH_LOW_F) begin
            digit = 4'(b - CH_LOW_A + 8'd10);
          end else if (b >= CH_UP_A && b <= CH_UP_F) begin
            digit = 4'(b - CH_UP_A + 8'd10);
          end else begin
            is_hex = 1'b0;
          end
          if (is_hex) begin
            dec_acc = (dec_acc << 4) + VALUE_BITS'(digit);
          end else begin
            emit_char(dec_acc);
            clear_escape();
            take_plain(b);
          end
        end
        MODE_OCT: begin
          if (b >= CH_ZERO && b <= CH_SEVEN) begin
            dec_acc   = (dec_acc << 3) + VALUE_BITS'(b - CH_ZERO);
            oct_count = oct_count + 2'd1;
            if (oct_count >= MAX_OCTAL_DIGITS) begin
              emit_char(dec_acc);
              clear_escape();
            end
          end else begin
            emit_char(dec_acc);
            clear_escape();
            take_plain(b);
          end
        end
        MODE_CARET: begin
          upper     = (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_GAP : b;
          caret_val = upper - CARET_OFS;
          emit_char(VALUE_BITS'(caret_val));
          clear_escape();
        end
        default: begin
          clear_escape();
          take_plain(b);
        end
      endcase
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Sender: hold the request until taken, then offer the next one
  always @(posedge clk) begin
    int i;
    char_result_t r;
    if (rst_n) begin
      if (push && !full) begin
        decode_text_byte(current_req.text, current_req.endm);
        if (current_req.typed) begin
          step_count    = current_req.n;
          step_chars[0] = current_req.v0;
          step_chars[1] = current_req.v1;
        end
        for (i = 0; i < step_count; i++) begin
          r.value = step_chars[i];
          r.last  = (i == step_count - 1);
          awaited_chars.push_back(r);
        end
        bytes_taken++;
      end
      if (!push || !full) begin
        if (text_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          current_req = text_requests.pop_front();
          in_text_byte <= current_req.text;
          in_end_mark  <= current_req.endm;
          push         <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each popped character with the oldest expectation
  always @(posedge clk) begin
    char_result_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        chars_seen++;
        if (awaited_chars.size() == 0) begin
          note_mismatch("unexpected character", 16'd0, out_char_value);
        end else begin
          want = awaited_chars.pop_front();
          if (out_char_value !== want.value) begin
            note_mismatch("char_value", want.value, out_char_value);
          end
          if (out_last_of_run !== want.last) begin
            note_mismatch("last_of_run", 16'(want.last), 16'(out_last_of_run));
          end
        end
      end
      pop <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic endm);
    text_request_t r;
    r      = '0;
    r.text = b;
    r.endm = endm;
    text_requests.push_back(r);
    items_queued++;
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 7))
      0: return CH_LOW_A;
      1: return CH_LOW_B;
      2: return CH_LOW_E;
      3: return CH_LOW_F;
      4: return CH_LOW_N;
      5: return CH_LOW_R;
      6: return CH_LOW_T;
      default: return CH_LOW_V;
    endcase
  endfunction

  function automatic logic [7:0] pick_hex_digit();
    logic [7:0] r;
    r = 8'($urandom_range(0, 21));
    if (r < 8'd10) return CH_ZERO + r;
    if (r < 8'd16) return CH_LOW_A + r - 8'd10;
    return CH_UP_A + r - 8'd16;
  endfunction

  // Build strings of escape tokens, mostly well formed, some cut short or noisy
  task automatic queue_random_strings(input int target);
    int          start;
    token_kind_e kind;
    logic [7:0]  b;
    start = items_queued;
    while (items_queued - start < target) begin
      repeat ($urandom_range(1, 6)) begin
        kind = token_kind_e'($urandom_range(0, 7));
        case (kind)
          TK_PLAIN: begin
            b = 8'($urandom_range(1, 255));
            queue_byte((b == CH_BSLASH) ? CH_LOW_Z : b, 1'b0);
          end
          TK_LETTER: begin
            queue_byte(CH_BSLASH, 1'b0);
            queue_byte(pick_letter(), 1'b0);
          end
          TK_HEX: begin
            queue_byte(CH_BSLASH, 1'b0);
            queue_byte($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X, 1'b0);
            repeat ($urandom_range(0, 7)) queue_byte(pick_hex_digit(), 1'b0);
          end
          TK_OCTAL: begin
            queue_byte(CH_BSLASH, 1'b0);
            repeat ($urandom_range(1, 4)) queue_byte(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
          end
          TK_CARET: begin
            queue_byte(CH_BSLASH, 1'b0);
            queue_byte(CH_CARET, 1'b0);
            queue_byte(8'($urandom), 1'b0);
          end
          TK_BS_ANY: begin
            queue_byte(CH_BSLASH, 1'b0);
            queue_byte(8'($urandom), 1'b0);
          end
          TK_CUT: begin
            // Open an escape and end the string inside it
            queue_byte(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 3))
              0: ;
              1: queue_byte(CH_CARET, 1'b0);
              2: begin
                queue_byte(CH_LOW_X, 1'b0);
                repeat ($urandom_range(0, 3)) queue_byte(pick_hex_digit(), 1'b0);
              end
              default: begin
                repeat ($urandom_range(1, 2)) begin
                  queue_byte(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
                end
              end
            endcase
            queue_byte(8'($urandom), 1'b1);
          end
          default: begin
            repeat ($urandom_range(1, 8)) queue_byte(8'($urandom), $urandom_range(0, 9) == 0);
          end
        endcase
      end
      queue_byte(8'($urandom), 1'b1);
      strings_sent++;
    end
  endtask

  task automatic wait_all_taken();
    while (bytes_taken != items_queued) @(posedge clk);
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall, input int items,
                           input bit drain_midway);
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    if (drain_midway) begin
      // Hold back the second half until every character has come out
      queue_random_strings(items / 2);
      wait_all_taken();
      while (awaited_chars.size() != 0) @(posedge clk);
      queue_random_strings(items - items / 2);
    end else begin
      queue_random_strings(items);
    end
    wait_all_taken();
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows first, with no idling on either side
    for (k = 0; k < DIR_ROWS; k++) begin
      text_requests.push_back(DIRECTED_ROWS[k]);
      items_queued++;
    end
    wait_all_taken();

    run_phase(0, 0, 500, 1'b0);
    run_phase(87, 0, 450, 1'b0);
    run_phase(0, 87, 450, 1'b1);
    run_phase(16, 16, 500, 1'b0);

    // Drain the remaining characters, then leave room for strays
    receiver_stall_pct = 0;
    while (awaited_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d text bytes in %0d random strings, %0d characters checked",
             bytes_taken, strings_sent, chars_seen);
    $display("Pacing: free flow, sparse sender, stalled receiver with a drain pause, mixed");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/esd_pkg.sv
hw/rtl/esd_front.sv
hw/rtl/esd_queue.sv
hw/rtl/esd_back.sv
hw/rtl/escape_sequence_decoder_unit.sv
test/escape_sequence_decoder_unit_test.sv
